// File: rtl/ckerng_pkg.sv
// shared types and constants for the chacha20 key erasure random byte generator
// no dependencies
package ckerng_pkg;

	typedef enum logic [1:0] {
		OP_SEED   = 2'd0,
		OP_LAST   = 2'd1,
		OP_FINISH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] rand_byte;
		logic       seeded;
	} res_t;

	typedef logic [15:0][31:0] blk_t;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned ROUNDS  = 20;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [7:0] KEY_BYTES   = 8'd32;
	localparam logic [3:0] NONCE_BYTES = 4'd12;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned c);
		rotl = (v << c) | (v >> (32 - c));
	endfunction

	// one quarter round on four words
	function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] ta, tb, tc, td;
		ta = a; tb = b; tc = c; td = d;
		ta = ta + tb; td = rotl(td ^ ta, 16);
		tc = tc + td; tb = rotl(tb ^ tc, 12);
		ta = ta + tb; td = rotl(td ^ ta, 8);
		tc = tc + td; tb = rotl(tb ^ tc, 7);
		qr = {ta, tb, tc, td};
	endfunction

	// one full round: column round on even steps, diagonal round on odd steps
	function automatic blk_t round_fn(input blk_t x, input logic diag);
		blk_t y;
		logic [127:0] r;
		y = x;
		if (!diag) begin
			for (int i = 0; i < 4; i++) begin
				r = qr(x[i], x[4 + i], x[8 + i], x[12 + i]);
				{y[i], y[4 + i], y[8 + i], y[12 + i]} = r;
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				r = qr(x[i], x[4 + (i + 1) % 4], x[8 + (i + 2) % 4], x[12 + (i + 3) % 4]);
				{y[i], y[4 + (i + 1) % 4], y[8 + (i + 2) % 4], y[12 + (i + 3) % 4]} = r;
			end
		end
		round_fn = y;
	endfunction

endpackage

// File: rtl/ckerng_front.sv
// front part: input handshake and a short command queue
// depends on ckerng_pkg
module ckerng_front import ckerng_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output cmd_t q_cmd
);

	cmd_t       mem_q [Q_DEPTH];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'(Q_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/ckerng_back.sv
// back part: seeding, one-round-per-cycle chacha20 core, buffer and output register
// depends on ckerng_pkg
module ckerng_back import ckerng_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cmd_t q_cmd,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic [7:0][31:0] key_q;
	logic [2:0][31:0] nonce_q;
	logic [31:0]      ctr_q;
	logic [7:0]       buf_q [32];
	logic [5:0]       left_q;
	logic [7:0]       sidx_q;
	logic [3:0]       npos_q;
	logic             seeded_q;
	blk_t             init_q, work_q;
	logic             busy_q;
	logic [4:0]       rnd_q;
	logic             ovalid_q;
	res_t             ores_q;
	logic             fin_pend_q;

	blk_t             start_blk, fin_blk;
	logic             out_free, need_refill, go, start, done;
	logic [7:0][31:0] key_seed;
	logic [2:0][31:0] nonce_seed;
	logic [7:0]       nb;
	logic [4:0]       rpos;

	assign out_free = !ovalid_q || out_ready;
	assign need_refill = (left_q == 6'd0) || (left_q > 6'd32);
	// a read waits for a refill and a free output register; other commands go straight through
	always_comb begin
		go = 1'b0;
		if (q_valid && !busy_q) begin
			unique case (q_cmd.op)
				OP_READ:  go = out_free && !need_refill;
				default:  go = 1'b1;
			endcase
		end
	end
	assign q_ready = go;
	assign done = busy_q && (rnd_q == 5'(ROUNDS - 1));

	always_comb begin
		key_seed   = key_q;
		nonce_seed = nonce_q;
		nb = q_cmd.data + sidx_q;
		key_seed[sidx_q[4:2]][8 * sidx_q[1:0] +: 8] =
			key_q[sidx_q[4:2]][8 * sidx_q[1:0] +: 8] ^ q_cmd.data;
		if (npos_q < NONCE_BYTES) begin
			nonce_seed[npos_q[3:2]][8 * npos_q[1:0] +: 8] =
				nonce_q[npos_q[3:2]][8 * npos_q[1:0] +: 8] ^ nb;
		end else begin
			nonce_seed[0][7:0] = nonce_q[0][7:0] ^ nb;
		end
	end

	// refill starts on last or finish, or when a read is waiting on an empty buffer
	always_comb begin
		start = 1'b0;
		start_blk = '0;
		start_blk[0] = SIGMA0; start_blk[1] = SIGMA1;
		start_blk[2] = SIGMA2; start_blk[3] = SIGMA3;
		start_blk[11:4] = key_q;
		start_blk[12] = ctr_q;
		start_blk[15:13] = nonce_q;
		if (go && q_cmd.op == OP_LAST) begin
			start = 1'b1;
			start_blk[11:4] = key_seed;
			start_blk[15:13] = nonce_seed;
		end else if (go && q_cmd.op == OP_FINISH) begin
			start = 1'b1;
		end else if (q_valid && !busy_q && q_cmd.op == OP_READ && need_refill) begin
			start = 1'b1;
		end
	end

	always_comb begin
		fin_blk = round_fn(work_q, rnd_q[0]);
		for (int i = 0; i < 16; i++) begin
			fin_blk[i] = fin_blk[i] + init_q[i];
		end
	end

	assign rpos = 5'(6'd32 - left_q);

	always_ff @(posedge clk) begin
		if (start) begin
			init_q <= start_blk;
			work_q <= start_blk;
		end else if (busy_q) begin
			work_q <= round_fn(work_q, rnd_q[0]);
		end
		if (done) begin
			for (int i = 0; i < 32; i++) begin
				buf_q[i] <= fin_blk[8 + i / 4][8 * (i % 4) +: 8];
			end
		end
		if (go && q_cmd.op == OP_READ) begin
			ores_q.rand_byte <= buf_q[rpos];
			ores_q.seeded    <= seeded_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			nonce_q  <= '0;
			ctr_q    <= '0;
			left_q   <= '0;
			sidx_q   <= '0;
			npos_q   <= '0;
			seeded_q <= 1'b0;
			busy_q   <= 1'b0;
			rnd_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (go) begin
				unique case (q_cmd.op)
					OP_SEED: begin
						key_q   <= key_seed;
						nonce_q <= nonce_seed;
						sidx_q  <= sidx_q + 8'd1;
						npos_q  <= (npos_q >= NONCE_BYTES - 4'd1) ? 4'd0 : npos_q + 4'd1;
					end
					OP_LAST, OP_FINISH: begin
						// the last seed byte also lands in the nonce kept across refills
						if (q_cmd.op == OP_LAST) begin
							nonce_q <= nonce_seed;
						end
						seeded_q <= 1'b1;
						sidx_q   <= '0;
						npos_q   <= '0;
						left_q   <= '0;
					end
					OP_READ: begin
						left_q   <= left_q - 6'd1;
						ovalid_q <= 1'b1;
					end
				endcase
			end
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 5'd1;
			end
			if (done) begin
				busy_q <= 1'b0;
				key_q  <= fin_blk[7:0];
				ctr_q  <= ctr_q + 32'd1;
				if (ctr_q == '1) begin
					nonce_q[0] <= nonce_q[0] + 32'd1;
					if (nonce_q[0] == '1) begin
						nonce_q[1] <= nonce_q[1] + 32'd1;
						if (nonce_q[1] == '1) begin
							nonce_q[2] <= nonce_q[2] + 32'd1;
						end
					end
				end
				// a last or finish refill discards its output
				left_q <= fin_pend_q ? 6'd0 : 6'd32;
			end
		end
	end

	// last and finish refills leave the buffer empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_pend_q <= 1'b0;
		end else if (start) begin
			fin_pend_q <= go;
		end
	end

	assign out_valid = ovalid_q;
	assign out_res   = ores_q;

endmodule

// File: rtl/chacha20_key_erasure_rng_core.sv
// channel         | dir | tdata                          | tuser
// s_axis          | in  | [7:0] data_byte                | [1:0] opcode
// m_axis          | out | [7:0] rand_byte                | [0] seeded
// a read from a filled buffer takes one beat per cycle unless the output register
// is stalled; a read on an empty buffer waits for a refill of 20 rounds
// last and finish opcodes start a refill whose output is discarded
// a 2-entry command queue decouples input from the core; the output register
// holds a beat while m_axis_tready is low
// depends on ckerng_pkg, ckerng_front, ckerng_back
module chacha20_key_erasure_rng_core import ckerng_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // data_byte
	input  logic [1:0] s_axis_tuser,  // opcode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // rand_byte
	output logic       m_axis_tuser   // seeded
);

	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	assign in_cmd.op   = op_t'(s_axis_tuser);
	assign in_cmd.data = s_axis_tdata;

	ckerng_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	ckerng_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = res.rand_byte;
	assign m_axis_tuser = res.seeded;

	a_no_pop_no_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> q_valid) else $error("command taken from empty queue");
	a_seeded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |=> (!m_axis_tvalid || m_axis_tuser))
		else $error("seeded flag dropped");

endmodule
